// ----- rtl/sjs_pkg.sv -----
`timescale 1ns / 1ps

package sjs_pkg;

    // Table and field sizes
    localparam int SLOTS      = 16;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_BITS    = 8;
    localparam int BURST_BITS = 8;
    localparam int TIME_BITS  = 16;

    // Request kinds on the mode field
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Request travelling down the row of slot cells, one cell per cycle.
    // On an arrival, hit marks that a free slot took the job (or that the
    // request is void). On a tick, hit marks that a candidate is carried.
    typedef struct packed {
        logic                  go;
        logic                  tick;
        logic                  hit;
        logic [ID_BITS-1:0]    id;
        logic [BURST_BITS-1:0] rem;
        logic [TIME_BITS-1:0]  arr;
        logic [BURST_BITS-1:0] bst;
        logic [SLOT_BITS-1:0]  idx;
    } wave_t;

    // Run-one-unit command broadcast to the chosen slot
    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] idx;
    } upd_t;

endpackage

// ----- rtl/sjs_cell.sv -----
`timescale 1ns / 1ps

module sjs_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sjs_pkg::SLOT_BITS-1:0] idx,
    input  sjs_pkg::wave_t                wave_in,
    output sjs_pkg::wave_t                wave_out,
    input  sjs_pkg::upd_t                 upd
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [sjs_pkg::ID_BITS-1:0]    job_reg;
    logic [sjs_pkg::BURST_BITS-1:0] rem_reg;
    logic [sjs_pkg::TIME_BITS-1:0]  arr_reg;
    logic [sjs_pkg::BURST_BITS-1:0] bst_reg;
    sjs_pkg::wave_t                 wave_reg;
    sjs_pkg::wave_t                 wave_next;
    logic                           store;
    logic                           run_me;

    // Claim a free slot for an arrival, or challenge the tick candidate
    always_comb
    begin
        wave_next = wave_in;
        store     = 1'b0;
        if (wave_in.go)
        begin
            if (wave_in.tick == sjs_pkg::MODE_ARRIVE)
            begin
                if (!valid_reg && !wave_in.hit)
                begin
                    store         = 1'b1;
                    wave_next.hit = 1'b1;
                end
            end
            else if (valid_reg && (!wave_in.hit || (rem_reg < wave_in.rem) ||
                     ((rem_reg == wave_in.rem) && (job_reg < wave_in.id))))
            begin
                wave_next.hit = 1'b1;
                wave_next.id  = job_reg;
                wave_next.rem = rem_reg;
                wave_next.arr = arr_reg;
                wave_next.bst = bst_reg;
                wave_next.idx = idx;
            end
        end
    end

    assign run_me = upd.en && (upd.idx == idx);

    // Mark the slot valid on a store; free it when its last unit runs
    always_comb
    begin
        valid_next = valid_reg;
        if (store)
        begin
            valid_next = 1'b1;
        end
        else if (run_me && (rem_reg == sjs_pkg::BURST_BITS'(1)))
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            wave_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            wave_reg  <= wave_next;
        end
    end

    // Load the job on arrival, count down on each unit run
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            job_reg <= wave_in.id;
            rem_reg <= wave_in.rem;
            arr_reg <= wave_in.arr;
            bst_reg <= wave_in.rem;
        end
        else if (run_me)
        begin
            rem_reg <= rem_reg - sjs_pkg::BURST_BITS'(1);
        end
    end

    assign wave_out = wave_reg;

endmodule

// ----- rtl/sjs_ctrl.sv -----
`timescale 1ns / 1ps

module sjs_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [sjs_pkg::ID_BITS-1:0]    job_id,
    input  logic [sjs_pkg::BURST_BITS-1:0] burst,
    output sjs_pkg::wave_t                 head,
    input  sjs_pkg::wave_t                 tail,
    output sjs_pkg::upd_t                  upd,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           accepted,
    output logic                           ran,
    output logic [sjs_pkg::ID_BITS-1:0]    ran_id,
    output logic                           finished,
    output logic [sjs_pkg::TIME_BITS-1:0]  finish_time,
    output logic [sjs_pkg::TIME_BITS-1:0]  turnaround,
    output logic [sjs_pkg::TIME_BITS-1:0]  waiting
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [sjs_pkg::TIME_BITS-1:0] time_reg;
    logic [sjs_pkg::TIME_BITS-1:0] time_next;
    logic                          void_reg;
    logic                          void_next;
    sjs_pkg::wave_t                res_reg;
    sjs_pkg::wave_t                res_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          accepted_reg;
    logic                          accepted_next;
    logic                          ran_reg;
    logic                          ran_next;
    logic [sjs_pkg::ID_BITS-1:0]   ran_id_reg;
    logic [sjs_pkg::ID_BITS-1:0]   ran_id_next;
    logic                          finished_reg;
    logic                          finished_next;
    logic [sjs_pkg::TIME_BITS-1:0] finish_time_reg;
    logic [sjs_pkg::TIME_BITS-1:0] finish_time_next;
    logic [sjs_pkg::TIME_BITS-1:0] turnaround_reg;
    logic [sjs_pkg::TIME_BITS-1:0] turnaround_next;
    logic [sjs_pkg::TIME_BITS-1:0] waiting_reg;
    logic [sjs_pkg::TIME_BITS-1:0] waiting_next;

    logic                          accept;
    logic                          load;
    logic                          done_job;
    logic [sjs_pkg::TIME_BITS-1:0] time_inc;
    logic [sjs_pkg::TIME_BITS-1:0] tat;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load     = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Launch the request into the first cell; a zero-burst arrival enters already void
    always_comb
    begin
        head      = '0;
        head.go   = accept;
        head.tick = mode;
        head.hit  = (mode == sjs_pkg::MODE_ARRIVE) && (burst == '0);
        head.id   = job_id;
        head.rem  = burst;
        head.arr  = time_reg;
        head.bst  = burst;
    end

    // Run the chosen job for one unit when its result is loaded
    assign done_job = (res_reg.tick == sjs_pkg::MODE_TICK) && res_reg.hit;
    assign upd.en   = load && done_job;
    assign upd.idx  = res_reg.idx;

    assign time_inc = time_reg + sjs_pkg::TIME_BITS'(1);
    assign tat      = time_inc - res_reg.arr;

    always_comb
    begin
        state_next       = state_reg;
        time_next        = time_reg;
        void_next        = void_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg;
        accepted_next    = accepted_reg;
        ran_next         = ran_reg;
        ran_id_next      = ran_id_reg;
        finished_next    = finished_reg;
        finish_time_next = finish_time_reg;
        turnaround_next  = turnaround_reg;
        waiting_next     = waiting_reg;

        // Drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    void_next  = head.hit;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tail.go)
                begin
                    res_next   = tail;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    out_valid_next   = 1'b1;
                    accepted_next    = 1'b0;
                    ran_next         = 1'b0;
                    ran_id_next      = '0;
                    finished_next    = 1'b0;
                    finish_time_next = '0;
                    turnaround_next  = '0;
                    waiting_next     = '0;
                    if (res_reg.tick == sjs_pkg::MODE_TICK)
                    begin
                        time_next = time_inc;
                        if (res_reg.hit)
                        begin
                            ran_next    = 1'b1;
                            ran_id_next = res_reg.id;
                            if (res_reg.rem == sjs_pkg::BURST_BITS'(1))
                            begin
                                finished_next    = 1'b1;
                                finish_time_next = time_inc;
                                turnaround_next  = tat;
                                waiting_next     = tat - sjs_pkg::TIME_BITS'(res_reg.bst);
                            end
                        end
                    end
                    else
                    begin
                        accepted_next = res_reg.hit && !void_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            time_reg        <= '0;
            void_reg        <= 1'b0;
            res_reg         <= '0;
            out_valid_reg   <= 1'b0;
            accepted_reg    <= 1'b0;
            ran_reg         <= 1'b0;
            ran_id_reg      <= '0;
            finished_reg    <= 1'b0;
            finish_time_reg <= '0;
            turnaround_reg  <= '0;
            waiting_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            time_reg        <= time_next;
            void_reg        <= void_next;
            res_reg         <= res_next;
            out_valid_reg   <= out_valid_next;
            accepted_reg    <= accepted_next;
            ran_reg         <= ran_next;
            ran_id_reg      <= ran_id_next;
            finished_reg    <= finished_next;
            finish_time_reg <= finish_time_next;
            turnaround_reg  <= turnaround_next;
            waiting_reg     <= waiting_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign ran         = ran_reg;
    assign ran_id      = ran_id_reg;
    assign finished    = finished_reg;
    assign finish_time = finish_time_reg;
    assign turnaround  = turnaround_reg;
    assign waiting     = waiting_reg;

endmodule

// ----- rtl/srtf_job_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    mode, job_id, burst
// out      output     out_valid / out_ready  accepted, ran, ran_id, finished,
//                                            finish_time, turnaround, waiting
//
// Each request walks the row of 16 slot cells, one cell per cycle. The result
// passes from the last cell into the result register and then into the output
// register, after which the next request can be taken.
// One request is in flight at a time; the next is taken as soon as the
// result sits in the output register, even if it has not been taken yet.
// A stalled output holds the finished request until the register frees.
// Reset clears all slot valid bits and the time at once; no clearing pass.

module srtf_job_scheduler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [sjs_pkg::ID_BITS-1:0]    job_id,
    input  logic [sjs_pkg::BURST_BITS-1:0] burst,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           accepted,
    output logic                           ran,
    output logic [sjs_pkg::ID_BITS-1:0]    ran_id,
    output logic                           finished,
    output logic [sjs_pkg::TIME_BITS-1:0]  finish_time,
    output logic [sjs_pkg::TIME_BITS-1:0]  turnaround,
    output logic [sjs_pkg::TIME_BITS-1:0]  waiting
);

    sjs_pkg::wave_t              waves [0:sjs_pkg::SLOTS];
    sjs_pkg::upd_t               upd;
    logic [sjs_pkg::SLOTS-1:0]   go_vec;

    // Sequence requests and build results
    sjs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .job_id      (job_id),
        .burst       (burst),
        .head        (waves[0]),
        .tail        (waves[sjs_pkg::SLOTS]),
        .upd         (upd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .ran         (ran),
        .ran_id      (ran_id),
        .finished    (finished),
        .finish_time (finish_time),
        .turnaround  (turnaround),
        .waiting     (waiting)
    );

    // Row of slot cells, lowest slot first
    for (genvar k = 0; k < sjs_pkg::SLOTS; k++)
    begin : g_cell
        sjs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (sjs_pkg::SLOT_BITS'(k)),
            .wave_in  (waves[k]),
            .wave_out (waves[k+1]),
            .upd      (upd)
        );
        assign go_vec[k] = waves[k+1].go;
    end

`ifndef NO_ASSERTIONS
    // At most one request travels the row
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(go_vec))
        else $error("more than one request in the slot row");

    // Taking a new request means the row is empty
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> (go_vec == '0))
        else $error("request accepted while the row is busy");

    // A finished job must have run and cannot be an arrival
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (ran && !accepted))
        else $error("finish reported without a run");
`endif

endmodule

// ----- tb/tb_srtf_job_scheduler_unit.sv -----
`timescale 1ns / 1ps

module tb_srtf_job_scheduler_unit;
    import sjs_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);
    localparam int MIX_BLOCKS   = 18;
    localparam int MIX_LENGTH   = 100;
    localparam int LONG_TICKS   = 100;

    typedef enum int {MIX_LIGHT, MIX_HEAVY, MIX_DRAIN} mix_t;

    typedef struct packed {
        logic                 accepted;
        logic                 ran;
        logic [ID_BITS-1:0]   ran_id;
        logic                 finished;
        logic [TIME_BITS-1:0] finish_time;
        logic [TIME_BITS-1:0] turnaround;
        logic [TIME_BITS-1:0] waiting;
    } sched_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  mode;
    logic [ID_BITS-1:0]    job_id;
    logic [BURST_BITS-1:0] burst;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  accepted;
    logic                  ran;
    logic [ID_BITS-1:0]    ran_id;
    logic                  finished;
    logic [TIME_BITS-1:0]  finish_time;
    logic [TIME_BITS-1:0]  turnaround;
    logic [TIME_BITS-1:0]  waiting;

    // Scheduler shadow: job table and clock as the block should hold them
    logic                  job_live   [SLOTS];
    logic [ID_BITS-1:0]    job_ident  [SLOTS];
    logic [BURST_BITS-1:0] job_left   [SLOTS];
    logic [BURST_BITS-1:0] job_length [SLOTS];
    logic [TIME_BITS-1:0]  job_stamp  [SLOTS];
    logic [TIME_BITS-1:0]  sched_now;

    sched_result_t pending_results[$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            stall_left  = 0;
    bit            bubbles_on  = 1'b1;

    srtf_job_scheduler_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .job_id      (job_id),
        .burst       (burst),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .ran         (ran),
        .ran_id      (ran_id),
        .finished    (finished),
        .finish_time (finish_time),
        .turnaround  (turnaround),
        .waiting     (waiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_srtf_job_scheduler_unit: done, errors");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Advance the shadow scheduler by one request and return the result it owes
    task automatic schedule_step(input logic m, input logic [ID_BITS-1:0] id,
                                 input logic [BURST_BITS-1:0] len,
                                 output sched_result_t r);
        int                   pick;
        logic [TIME_BITS-1:0] span;
        r    = '0;
        pick = -1;
        if (m == MODE_ARRIVE)
        begin
            // store in the lowest free slot; a zero burst or a full table drops it
            if (len != '0)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!job_live[i] && !r.accepted)
                    begin
                        job_live[i]   = 1'b1;
                        job_ident[i]  = id;
                        job_left[i]   = len;
                        job_length[i] = len;
                        job_stamp[i]  = sched_now;
                        r.accepted    = 1'b1;
                    end
                end
            end
        end
        else
        begin
            // least remaining time wins, then the lower id, then the lower slot
            for (int i = 0; i < SLOTS; i++)
            begin
                if (job_live[i])
                begin
                    if (pick < 0)
                        pick = i;
                    else if (job_left[i] < job_left[pick] ||
                             (job_left[i] == job_left[pick] &&
                              job_ident[i] < job_ident[pick]))
                        pick = i;
                end
            end
            sched_now = sched_now + 1'b1;
            if (pick >= 0)
            begin
                r.ran          = 1'b1;
                r.ran_id       = job_ident[pick];
                job_left[pick] = job_left[pick] - 1'b1;
                if (job_left[pick] == '0)
                begin
                    span           = sched_now - job_stamp[pick];
                    r.finished     = 1'b1;
                    r.finish_time  = sched_now;
                    r.turnaround   = span;
                    r.waiting      = span - TIME_BITS'(job_length[pick]);
                    job_live[pick] = 1'b0;
                end
            end
        end
    endtask

    // Hold one request until taken; queue the result it should produce
    task automatic send_request(input logic m, input logic [ID_BITS-1:0] id,
                                input logic [BURST_BITS-1:0] len);
        sched_result_t r;
        if (bubbles_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = m;
        job_id   = id;
        burst    = len;
        do
            @(posedge clk);
        while (!in_ready);
        schedule_step(m, id, len, r);
        pending_results.insert(pending_results.size(), r);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_request(MODE_TICK, ID_BITS'($urandom), BURST_BITS'($urandom));
    endtask

    // Drive output backpressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if (bubbles_on && $urandom_range(0, 7) == 0)
        begin
            out_ready  = 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            out_ready = 1'b1;
    end

    // Compare each result with the oldest owed one
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_error("result with no request pending");
            else
            begin
                want = pending_results.pop_front();
                check_field("accepted", 32'(accepted), 32'(want.accepted));
                check_field("ran", 32'(ran), 32'(want.ran));
                check_field("ran_id", 32'(ran_id), 32'(want.ran_id));
                check_field("finished", 32'(finished), 32'(want.finished));
                check_field("finish_time", 32'(finish_time), 32'(want.finish_time));
                check_field("turnaround", 32'(turnaround), 32'(want.turnaround));
                check_field("waiting", 32'(waiting), 32'(want.waiting));
            end
        end
    end

    // Tick on an empty table: idle, time still moves
    task automatic test_idle_tick();
        send_tick();
    endtask

    // Zero burst is dropped; extreme ids and bursts are stored
    task automatic test_arrival_rejects();
        send_request(MODE_ARRIVE, 8'h00, 8'h00);
        send_request(MODE_ARRIVE, 8'hFF, 8'hFF);
        send_request(MODE_ARRIVE, 8'hA5, 8'h01);
        send_tick();
    endtask

    // Equal remaining time: lower id first, then lower slot for equal ids
    task automatic test_tie_break();
        send_request(MODE_ARRIVE, 8'h07, 8'h01);
        send_request(MODE_ARRIVE, 8'h07, 8'h01);
        send_request(MODE_ARRIVE, 8'h03, 8'h01);
        repeat (3) send_tick();
    endtask

    // Fill every slot, then one more arrival bounces
    task automatic test_full_table();
        for (int i = 1; i < SLOTS; i++)
            send_request(MODE_ARRIVE, ID_BITS'(i * 17), BURST_BITS'(i % 5 + 1));
        send_request(MODE_ARRIVE, 8'h3C, 8'h80);
    endtask

    // Blocks of light load, heavy load and pure draining
    task automatic test_random_mix();
        mix_t                  kind;
        int                    arrive_pct;
        int                    roll;
        logic [ID_BITS-1:0]    id;
        logic [BURST_BITS-1:0] len;
        for (int blk = 0; blk < MIX_BLOCKS; blk++)
        begin
            kind       = mix_t'($urandom_range(0, 2));
            arrive_pct = (kind == MIX_LIGHT) ? 15 : (kind == MIX_HEAVY) ? 60 : 0;
            for (int n = 0; n < MIX_LENGTH; n++)
            begin
                if ($urandom_range(0, 99) < arrive_pct)
                begin
                    id = ID_BITS'($urandom);
                    if ($urandom_range(0, 1) == 0)
                        id = ID_BITS'($urandom_range(0, 3));
                    roll = $urandom_range(0, 99);
                    if (kind == MIX_HEAVY && roll < 10)
                        len = BURST_BITS'($urandom);
                    else if (roll < 13)
                        len = '0;
                    else
                        len = BURST_BITS'($urandom_range(1, 6));
                    send_request(MODE_ARRIVE, id, len);
                end
                else
                    send_tick();
            end
        end
    endtask

    // Run two long jobs beside whatever is left, ticking back to back
    task automatic test_long_jobs();
        bit busy;
        int spins;
        send_request(MODE_ARRIVE, 8'h5A, 8'd30);
        send_request(MODE_ARRIVE, 8'hC3, 8'd60);
        busy  = 1'b1;
        spins = 0;
        while (busy && spins < LONG_TICKS)
        begin
            busy = 1'b0;
            for (int i = 0; i < SLOTS; i++)
                busy |= job_live[i];
            if (busy)
            begin
                send_tick();
                spins++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_ARRIVE;
        job_id    = '0;
        burst     = '0;
        sched_now = '0;
        foreach (job_live[i])
            job_live[i] = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_tick();
        test_arrival_rejects();
        test_tie_break();
        test_full_table();
        test_random_mix();
        bubbles_on = 1'b0;
        test_long_jobs();
        in_valid = 1'b0;

        // Let every owed result arrive, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_srtf_job_scheduler_unit: done, clean");
        else
            $display("tb_srtf_job_scheduler_unit: done, errors");
        $finish;
    end

endmodule
